@@ design/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Closest point on triangle: shared package
// Widths, payload structures, region codes and the split multiplier helpers
// used by every stage of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PR_W      = 2 * DIFF_W;
  localparam int DOT_W     = PR_W + 2;
  localparam int HALF_W    = DOT_W / 2;
  localparam int EDGE_W    = DOT_W + 2;
  localparam int VAL_W     = 2 * DOT_W;
  localparam int CHUNK_W   = (VAL_W + 2) / 3;
  localparam int TOP_W     = VAL_W - 2 * CHUNK_W;
  localparam int NUM_W     = DIFF_W + VAL_W + 4;
  localparam int DD_W      = VAL_W + 1;
  localparam int QUO_W     = 20;
  localparam int DIV_STEPS = QUO_W;
  localparam int OFF_W     = QUO_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0]              cvec_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef diff_t [2:0]               dvec_t;
  typedef logic signed [PR_W-1:0]    pr_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [VAL_W-1:0]   val_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic [NUM_W-1:0]          mag_t;
  typedef logic [DD_W-1:0]           dd_t;
  typedef logic [QUO_W-1:0]          quo_t;

  typedef enum logic [2:0] {
    REG_VERT_A  = 3'd0,
    REG_VERT_B  = 3'd1,
    REG_EDGE_AB = 3'd2,
    REG_VERT_C  = 3'd3,
    REG_EDGE_AC = 3'd4,
    REG_EDGE_BC = 3'd5,
    REG_FACE    = 3'd6
  } region_e;

  typedef struct packed {
    cvec_t p;
    cvec_t a;
    cvec_t b;
    cvec_t c;
  } query_t;

  typedef struct packed {
    cvec_t a;
    cvec_t b;
    cvec_t c;
    dvec_t ab;
    dvec_t ac;
    dvec_t bc;
    dot_t  d1;
    dot_t  d2;
    dot_t  d3;
    dot_t  d4;
    dot_t  d5;
    dot_t  d6;
  } geo_t;

  typedef struct packed {
    cvec_t   base;
    dvec_t   u;
    dvec_t   v;
    val_t    n1;
    val_t    n2;
    val_t    den;
    region_e region;
    logic    degen;
  } sel_t;

  typedef struct packed {
    cvec_t          base;
    logic [2:0]     neg;
    mag_t [2:0]     rem;
    quo_t [2:0]     quo;
    dd_t            dd;
    region_e        region;
    logic           degen;
  } dst_t;

  typedef struct packed {
    cvec_t   near;
    region_e region;
    logic    degen;
  } res_t;

  // Partial products of a wide signed product, split into halves.
  typedef struct packed {
    logic signed [2*HALF_W-1:0] hh;
    logic signed [2*HALF_W:0]   hl;
    logic signed [2*HALF_W:0]   lh;
    logic [2*HALF_W-1:0]        ll;
  } mp_t;

  typedef struct packed {
    logic signed [DIFF_W+TOP_W-1:0] p2;
    logic signed [DIFF_W+CHUNK_W:0] p1;
    logic signed [DIFF_W+CHUNK_W:0] p0;
  } np_t;

  function automatic mp_t mul_part(dot_t x, dot_t y);
    logic signed [HALF_W-1:0] xh;
    logic signed [HALF_W-1:0] yh;
    logic signed [HALF_W:0]   xl;
    logic signed [HALF_W:0]   yl;
    mp_t r;
    xh   = x[DOT_W-1:HALF_W];
    yh   = y[DOT_W-1:HALF_W];
    xl   = {1'b0, x[HALF_W-1:0]};
    yl   = {1'b0, y[HALF_W-1:0]};
    r.hh = xh * yh;
    r.hl = xh * yl;
    r.lh = xl * yh;
    r.ll = x[HALF_W-1:0] * y[HALF_W-1:0];
    return r;
  endfunction

  function automatic val_t mul_join(mp_t m);
    return (val_t'(m.hh) <<< (2 * HALF_W)) + (val_t'(m.hl) <<< HALF_W)
         + (val_t'(m.lh) <<< HALF_W) + val_t'(m.ll);
  endfunction

  function automatic np_t mul_np_part(diff_t x, val_t y);
    logic signed [TOP_W-1:0] y2;
    logic signed [CHUNK_W:0] y1;
    logic signed [CHUNK_W:0] y0;
    np_t r;
    y2   = y[VAL_W-1:2*CHUNK_W];
    y1   = {1'b0, y[2*CHUNK_W-1:CHUNK_W]};
    y0   = {1'b0, y[CHUNK_W-1:0]};
    r.p2 = x * y2;
    r.p1 = x * y1;
    r.p0 = x * y0;
    return r;
  endfunction

  function automatic num_t mul_np_join(np_t m);
    return (num_t'(m.p2) <<< (2 * CHUNK_W)) + (num_t'(m.p1) <<< CHUNK_W) + num_t'(m.p0);
  endfunction

endpackage

`default_nettype wire

@@ design/cpt_front.sv @@
// ----------------------------------------------------------------------------
// Closest point on triangle: front end
// Edge vectors, then the six dot products over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cpt_pkg::query_t query_i,
  output logic            valid_o,
  output cpt_pkg::geo_t   geo_o
);
  import cpt_pkg::*;

  logic [2:0] vld_q;

  cvec_t a1_q, b1_q, c1_q;
  dvec_t ab1_q, ac1_q, bc1_q, ap_q, bp_q, cp_q;

  cvec_t a2_q, b2_q, c2_q;
  dvec_t ab2_q, ac2_q, bc2_q;
  pr_t   prod_q [6][3];

  geo_t  geo_q;

  dvec_t lv [6];
  dvec_t rv [6];
  dot_t  dsum [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Stage one: edge and offset vectors.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= query_i.a;
      b1_q <= query_i.b;
      c1_q <= query_i.c;
      for (int k = 0; k < 3; k++) begin
        ab1_q[k] <= diff_t'(query_i.b[k]) - diff_t'(query_i.a[k]);
        ac1_q[k] <= diff_t'(query_i.c[k]) - diff_t'(query_i.a[k]);
        bc1_q[k] <= diff_t'(query_i.c[k]) - diff_t'(query_i.b[k]);
        ap_q[k]  <= diff_t'(query_i.p[k]) - diff_t'(query_i.a[k]);
        bp_q[k]  <= diff_t'(query_i.p[k]) - diff_t'(query_i.b[k]);
        cp_q[k]  <= diff_t'(query_i.p[k]) - diff_t'(query_i.c[k]);
      end
    end
  end

  always_comb begin
    lv[0] = ab1_q; rv[0] = ap_q;
    lv[1] = ac1_q; rv[1] = ap_q;
    lv[2] = ab1_q; rv[2] = bp_q;
    lv[3] = ac1_q; rv[3] = bp_q;
    lv[4] = ab1_q; rv[4] = cp_q;
    lv[5] = ac1_q; rv[5] = cp_q;
  end

  // Stage two: component products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      c2_q  <= c1_q;
      ab2_q <= ab1_q;
      ac2_q <= ac1_q;
      bc2_q <= bc1_q;
      for (int j = 0; j < 6; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[j][k] <= lv[j][k] * rv[j][k];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dsum[j] = dot_t'(prod_q[j][0]) + dot_t'(prod_q[j][1]) + dot_t'(prod_q[j][2]);
    end
  end

  // Stage three: dot products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_q.a  <= a2_q;
      geo_q.b  <= b2_q;
      geo_q.c  <= c2_q;
      geo_q.ab <= ab2_q;
      geo_q.ac <= ac2_q;
      geo_q.bc <= bc2_q;
      geo_q.d1 <= dsum[0];
      geo_q.d2 <= dsum[1];
      geo_q.d3 <= dsum[2];
      geo_q.d4 <= dsum[3];
      geo_q.d5 <= dsum[4];
      geo_q.d6 <= dsum[5];
    end
  end

  assign valid_o = vld_q[2];
  assign geo_o   = geo_q;

endmodule

`default_nettype wire

@@ design/cpt_cross.sv @@
// ----------------------------------------------------------------------------
// Closest point on triangle: region classification
// Cross terms of the dot products, Voronoi region tests and selection of the
// base point, directions, weights and denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_cross (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cpt_pkg::geo_t geo_i,
  output logic          valid_o,
  output cpt_pkg::sel_t sel_o
);
  import cpt_pkg::*;

  logic [4:0] vld_q;

  geo_t    geo4_q, geo5_q, geo6_q, geo7_q;
  mp_t     mp_q [6];
  edge_t   e1_4_q, e2_4_q, e1_5_q, e2_5_q, e1_6_q, e2_6_q;
  val_t    pv_q [6];
  val_t    va_q, vb_q, vc_q;
  edge_t   dab_q, dac_q, dbc_q;
  region_e region7_q;
  logic    degen7_q;
  val_t    den7_q, n1_7_q, n2_7_q;
  sel_t    sel_q;

  val_t    den_face;
  region_e region_d;
  logic    degen_d;
  val_t    den_d, n1_d, n2_d;
  logic    den_pos;
  sel_t    sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Stages four and five: the six cross products as split multiplies.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo4_q <= geo_i;
      mp_q[0] <= mul_part(geo_i.d1, geo_i.d4);
      mp_q[1] <= mul_part(geo_i.d3, geo_i.d2);
      mp_q[2] <= mul_part(geo_i.d5, geo_i.d2);
      mp_q[3] <= mul_part(geo_i.d1, geo_i.d6);
      mp_q[4] <= mul_part(geo_i.d3, geo_i.d6);
      mp_q[5] <= mul_part(geo_i.d5, geo_i.d4);
      e1_4_q <= edge_t'(geo_i.d4) - edge_t'(geo_i.d3);
      e2_4_q <= edge_t'(geo_i.d5) - edge_t'(geo_i.d6);

      geo5_q <= geo4_q;
      e1_5_q <= e1_4_q;
      e2_5_q <= e2_4_q;
      for (int j = 0; j < 6; j++) begin
        pv_q[j] <= mul_join(mp_q[j]);
      end

      // Stage six: barycentric weights and edge denominators.
      geo6_q <= geo5_q;
      e1_6_q <= e1_5_q;
      e2_6_q <= e2_5_q;
      vc_q   <= pv_q[0] - pv_q[1];
      vb_q   <= pv_q[2] - pv_q[3];
      va_q   <= pv_q[4] - pv_q[5];
      dab_q  <= edge_t'(geo5_q.d1) - edge_t'(geo5_q.d3);
      dac_q  <= edge_t'(geo5_q.d2) - edge_t'(geo5_q.d6);
      dbc_q  <= e1_5_q + e2_5_q;
    end
  end

  // Stage seven: region tests in the usual order.
  always_comb begin
    den_face = va_q + vb_q + vc_q;
    degen_d  = 1'b0;
    den_d    = val_t'(1);
    n1_d     = '0;
    n2_d     = '0;
    if (geo6_q.d1 <= 0 && geo6_q.d2 <= 0) begin
      region_d = REG_VERT_A;
    end else if (geo6_q.d3 >= 0 && geo6_q.d3 >= geo6_q.d4) begin
      region_d = REG_VERT_B;
    end else if (vc_q <= 0 && geo6_q.d1 >= 0 && geo6_q.d3 <= 0) begin
      region_d = REG_EDGE_AB;
      den_d    = val_t'(dab_q);
      n1_d     = val_t'(geo6_q.d1);
    end else if (geo6_q.d6 >= 0 && geo6_q.d6 >= geo6_q.d5) begin
      region_d = REG_VERT_C;
    end else if (vb_q <= 0 && geo6_q.d2 >= 0 && geo6_q.d6 <= 0) begin
      region_d = REG_EDGE_AC;
      den_d    = val_t'(dac_q);
      n1_d     = val_t'(geo6_q.d2);
    end else if (va_q <= 0 && e1_6_q >= 0 && e2_6_q >= 0) begin
      region_d = REG_EDGE_BC;
      den_d    = val_t'(dbc_q);
      n1_d     = val_t'(e1_6_q);
    end else if (den_face <= 0) begin
      region_d = REG_VERT_A;
      degen_d  = 1'b1;
    end else begin
      region_d = REG_FACE;
      den_d    = den_face;
      n1_d     = vb_q;
      n2_d     = vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo7_q    <= geo6_q;
      region7_q <= region_d;
      degen7_q  <= degen_d;
      den7_q    <= den_d;
      n1_7_q    <= n1_d;
      n2_7_q    <= n2_d;
      sel_q     <= sel_d;
    end
  end

  // Stage eight: a zero-length edge falls back to its start point.
  always_comb begin
    den_pos      = den7_q > 0;
    sel_d.den    = den_pos ? den7_q : val_t'(1);
    sel_d.n1     = den_pos ? n1_7_q : '0;
    sel_d.n2     = den_pos ? n2_7_q : '0;
    sel_d.region = region7_q;
    sel_d.degen  = degen7_q;
    sel_d.v      = geo7_q.ac;
    case (region7_q)
      REG_VERT_B, REG_EDGE_BC: sel_d.base = geo7_q.b;
      REG_VERT_C:              sel_d.base = geo7_q.c;
      default:                 sel_d.base = geo7_q.a;
    endcase
    case (region7_q)
      REG_EDGE_AC: sel_d.u = geo7_q.ac;
      REG_EDGE_BC: sel_d.u = geo7_q.bc;
      default:     sel_d.u = geo7_q.ab;
    endcase
  end

  assign valid_o = vld_q[4];
  assign sel_o   = sel_q;

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> sel_q.den > 0)
    else $error("selected denominator is not positive");

  a_degen_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] && sel_q.degen |-> sel_q.region == REG_VERT_A && sel_q.n1 == 0 && sel_q.n2 == 0)
    else $error("degenerate item does not return vertex A");

  a_vertex_no_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] && (sel_q.region == REG_VERT_A || sel_q.region == REG_VERT_B ||
                 sel_q.region == REG_VERT_C) |-> sel_q.n1 == 0 && sel_q.n2 == 0)
    else $error("vertex region carries a non-zero weight");

endmodule

`default_nettype wire

@@ design/cpt_numer.sv @@
// ----------------------------------------------------------------------------
// Closest point on triangle: numerator
// Weighted offset per axis, rounding bias and sign-magnitude split ahead of
// the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_numer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cpt_pkg::sel_t sel_i,
  output logic          valid_o,
  output cpt_pkg::dst_t dst_o
);
  import cpt_pkg::*;

  logic [2:0] vld_q;
  sel_t       sel9_q, sel10_q;
  np_t        np_q [3][2];
  num_t       x_q [3];
  dst_t       dst_q;

  num_t       m_d [3];
  dst_t       dst_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_comb begin
    dst_d.base   = sel10_q.base;
    dst_d.dd     = dd_t'(sel10_q.den) << 1;
    dst_d.quo    = '0;
    dst_d.region = sel10_q.region;
    dst_d.degen  = sel10_q.degen;
    for (int k = 0; k < 3; k++) begin
      // Twice the offset plus the denominator gives round to nearest.
      m_d[k]        = (x_q[k] <<< 1) + num_t'(sel10_q.den);
      dst_d.neg[k]  = m_d[k][NUM_W-1];
      dst_d.rem[k]  = dst_d.neg[k] ? mag_t'(-m_d[k]) : mag_t'(m_d[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel9_q <= sel_i;
      for (int k = 0; k < 3; k++) begin
        np_q[k][0] <= mul_np_part(sel_i.u[k], sel_i.n1);
        np_q[k][1] <= mul_np_part(sel_i.v[k], sel_i.n2);
      end
      sel10_q <= sel9_q;
      for (int k = 0; k < 3; k++) begin
        x_q[k] <= mul_np_join(np_q[k][0]) + mul_np_join(np_q[k][1]);
      end
      dst_q <= dst_d;
    end
  end

  assign valid_o = vld_q[2];
  assign dst_o   = dst_q;

endmodule

`default_nettype wire

@@ design/cpt_div.sv @@
// ----------------------------------------------------------------------------
// Closest point on triangle: divider and output stage
// Restoring division, one quotient bit per stage on all three axes, then
// floor correction, offset from the base point and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cpt_pkg::dst_t dst_i,
  output logic          valid_o,
  output cpt_pkg::res_t res_o
);
  import cpt_pkg::*;

  localparam logic signed [OFF_W:0] CMAX = (OFF_W + 1)'((1 <<< (COORD_W - 1)) - 1);
  localparam logic signed [OFF_W:0] CMIN = (OFF_W + 1)'(-(1 <<< (COORD_W - 1)));

  logic [DIV_STEPS-1:0] vld_q;
  logic                 out_vld_q;
  dst_t                 step_q [DIV_STEPS];
  dst_t                 src [DIV_STEPS];
  dst_t                 nxt [DIV_STEPS];
  mag_t                 trial [DIV_STEPS];
  res_t                 res_q;

  dst_t                 last;
  logic signed [OFF_W-1:0] qe [3];
  logic signed [OFF_W-1:0] off [3];
  logic signed [OFF_W:0]   sm [3];
  res_t                 res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[DIV_STEPS-2:0], valid_i};
      out_vld_q <= vld_q[DIV_STEPS-1];
    end
  end

  always_comb begin
    src[0] = dst_i;
    for (int g = 1; g < DIV_STEPS; g++) begin
      src[g] = step_q[g-1];
    end
    for (int g = 0; g < DIV_STEPS; g++) begin
      nxt[g]   = src[g];
      trial[g] = mag_t'(src[g].dd) << (DIV_STEPS - 1 - g);
      for (int k = 0; k < 3; k++) begin
        if (src[g].rem[k] >= trial[g]) begin
          nxt[g].rem[k]                    = src[g].rem[k] - trial[g];
          nxt[g].quo[k][DIV_STEPS - 1 - g] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < DIV_STEPS; g++) begin
        step_q[g] <= nxt[g];
      end
      res_q <= res_d;
    end
  end

  // Negative quotients round toward minus infinity when a remainder is left.
  always_comb begin
    last         = step_q[DIV_STEPS-1];
    res_d.region = last.region;
    res_d.degen  = last.degen;
    for (int k = 0; k < 3; k++) begin
      qe[k]  = $signed({2'b00, last.quo[k]});
      off[k] = last.neg[k] ? -(qe[k] + $signed({{(OFF_W-1){1'b0}}, |last.rem[k]})) : qe[k];
      sm[k]  = (OFF_W + 1)'(last.base[k]) + (OFF_W + 1)'(off[k]);
      if (sm[k] > CMAX) begin
        res_d.near[k] = CMAX[COORD_W-1:0];
      end else if (sm[k] < CMIN) begin
        res_d.near[k] = CMIN[COORD_W-1:0];
      end else begin
        res_d.near[k] = sm[k][COORD_W-1:0];
      end
    end
  end

  assign valid_o = out_vld_q;
  assign res_o   = res_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_STEPS-1] |-> step_q[DIV_STEPS-1].rem[0] < step_q[DIV_STEPS-1].dd &&
                           step_q[DIV_STEPS-1].rem[1] < step_q[DIV_STEPS-1].dd &&
                           step_q[DIV_STEPS-1].rem[2] < step_q[DIV_STEPS-1].dd)
    else $error("quotient overflowed the divider width");

endmodule

`default_nettype wire

@@ design/closest_point_on_triangle.sv @@
// ----------------------------------------------------------------------------
// Closest point on triangle
// Fully pipelined closest-point query with Voronoi region classification.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle while the output is not stalled; the
// 20-stage restoring divider and the split wide multipliers are all
// pipelined, so no unit is shared. A stall on the output freezes every
// stage at once and is passed back as stall_o in the same cycle. Reset
// clears only the valid bits; the data registers are not reset.
`default_nettype none

module closest_point_on_triangle (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [15:0]   point_x_i,
  input  logic signed [15:0]   point_y_i,
  input  logic signed [15:0]   point_z_i,
  input  logic signed [15:0]   vert_a_x_i,
  input  logic signed [15:0]   vert_a_y_i,
  input  logic signed [15:0]   vert_a_z_i,
  input  logic signed [15:0]   vert_b_x_i,
  input  logic signed [15:0]   vert_b_y_i,
  input  logic signed [15:0]   vert_b_z_i,
  input  logic signed [15:0]   vert_c_x_i,
  input  logic signed [15:0]   vert_c_y_i,
  input  logic signed [15:0]   vert_c_z_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic signed [15:0]   near_x_o,
  output logic signed [15:0]   near_y_o,
  output logic signed [15:0]   near_z_o,
  output logic [2:0]           region_o,
  output logic                 degenerate_o
);
  import cpt_pkg::*;

  // One enable for the whole pipeline: everything moves unless a result is
  // held on the output by the downstream side.
  logic   en;
  query_t query;
  logic   geo_vld, sel_vld, dst_vld, res_vld;
  geo_t   geo;
  sel_t   sel;
  dst_t   dst;
  res_t   res;

  assign en      = ~(res_vld & stall_i);
  assign stall_o = ~en;

  // Component order in each vector is x, y, z at indices 0, 1, 2.
  assign query.p = {point_z_i, point_y_i, point_x_i};
  assign query.a = {vert_a_z_i, vert_a_y_i, vert_a_x_i};
  assign query.b = {vert_b_z_i, vert_b_y_i, vert_b_x_i};
  assign query.c = {vert_c_z_i, vert_c_y_i, vert_c_x_i};

  // Edge vectors and the six dot products of the region tests.
  cpt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .query_i (query),
    .valid_o (geo_vld),
    .geo_o   (geo)
  );

  // Barycentric cross terms, region decision and operand selection.
  cpt_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geo_vld),
    .geo_i   (geo),
    .valid_o (sel_vld),
    .sel_o   (sel)
  );

  // Weighted numerators with the rounding bias folded in.
  cpt_numer u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sel_vld),
    .sel_i   (sel),
    .valid_o (dst_vld),
    .dst_o   (dst)
  );

  // Division, floor correction and the output register.
  cpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dst_vld),
    .dst_i   (dst),
    .valid_o (res_vld),
    .res_o   (res)
  );

  assign valid_o      = res_vld;
  assign near_x_o     = res.near[0];
  assign near_y_o     = res.near[1];
  assign near_z_o     = res.near[2];
  assign region_o     = res.region;
  assign degenerate_o = res.degen;

endmodule

`default_nettype wire

@@ bench/closest_point_on_triangle_tb.sv @@
// ----------------------------------------------------------------------------
// Closest point on triangle: self-checking testbench
// Sends query items with random gaps into the pipeline and stalls the output
// at random. It predicts every result with exact wide integer arithmetic and
// compares the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module closest_point_on_triangle_tb;
  import cpt_pkg::*;

  // Wide enough for every product and numerator that the geometry produces.
  typedef logic signed [127:0] wide_t;

  localparam int NUM_RANDOM  = 1700;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN       = 48;

  logic   clk_i;
  logic   rst_ni;
  logic   valid_i;
  logic   stall_o;
  coord_t point_x_i, point_y_i, point_z_i;
  coord_t vert_a_x_i, vert_a_y_i, vert_a_z_i;
  coord_t vert_b_x_i, vert_b_y_i, vert_b_z_i;
  coord_t vert_c_x_i, vert_c_y_i, vert_c_z_i;
  logic   valid_o;
  logic   stall_i;
  coord_t near_x_o, near_y_o, near_z_o;
  logic [2:0] region_o;
  logic   degenerate_o;

  closest_point_on_triangle u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .vert_a_x_i   (vert_a_x_i),
    .vert_a_y_i   (vert_a_y_i),
    .vert_a_z_i   (vert_a_z_i),
    .vert_b_x_i   (vert_b_x_i),
    .vert_b_y_i   (vert_b_y_i),
    .vert_b_z_i   (vert_b_z_i),
    .vert_c_x_i   (vert_c_x_i),
    .vert_c_y_i   (vert_c_y_i),
    .vert_c_z_i   (vert_c_z_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .near_x_o     (near_x_o),
    .near_y_o     (near_y_o),
    .near_z_o     (near_z_o),
    .region_o     (region_o),
    .degenerate_o (degenerate_o)
  );

  // Queries waiting to be driven, and results that the pipeline still owes.
  query_t pending_queries[$];
  res_t   owed_results[$];

  int  error_count;
  int  cycle_count;
  int  checked_count;
  int  region_hits[7];
  int  degen_hits;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Floor division for a positive divisor; the operator truncates toward zero.
  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (n < 0 && q * d != n) q = q - 1;
    return q;
  endfunction

  function automatic coord_t clamp_coord(wide_t v);
    if (v < -32768) return coord_t'(-32768);
    if (v > 32767) return coord_t'(32767);
    return coord_t'(v);
  endfunction

  // One coordinate of base + (u*n1 + v*n2) / den, rounded to nearest with ties
  // upwards. A divisor that is not positive leaves the base point unchanged,
  // which is how a zero-length edge comes back as its start point.
  function automatic coord_t project_coord(wide_t base, wide_t u, wide_t n1,
                                           wide_t v, wide_t n2, wide_t den);
    wide_t num;
    if (den <= 0) return clamp_coord(base);
    num = base * den + u * n1 + v * n2;
    return clamp_coord(floor_div(2 * num + den, 2 * den));
  endfunction

  function automatic wide_t dot3(wide_t x[3], wide_t y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic res_t nearest_point(query_t q);
    wide_t p[3], a[3], b[3], c[3];
    wide_t ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, den;
    res_t r;
    for (int k = 0; k < 3; k++) begin
      p[k]  = $signed(q.p[k]);
      a[k]  = $signed(q.a[k]);
      b[k]  = $signed(q.b[k]);
      c[k]  = $signed(q.c[k]);
      ab[k] = b[k] - a[k];
      ac[k] = c[k] - a[k];
      bc[k] = c[k] - b[k];
      ap[k] = p[k] - a[k];
      bp[k] = p[k] - b[k];
      cp[k] = p[k] - c[k];
    end
    d1 = dot3(ab, ap);
    d2 = dot3(ac, ap);
    d3 = dot3(ab, bp);
    d4 = dot3(ac, bp);
    d5 = dot3(ab, cp);
    d6 = dot3(ac, cp);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    e1 = d4 - d3;
    e2 = d5 - d6;
    r.degen = 1'b0;
    // The regions are tested in the usual order: vertices and edges first,
    // the face interior last.
    if (d1 <= 0 && d2 <= 0) begin
      r.region = REG_VERT_A;
      for (int k = 0; k < 3; k++) r.near[k] = clamp_coord(a[k]);
    end else if (d3 >= 0 && d3 >= d4) begin
      r.region = REG_VERT_B;
      for (int k = 0; k < 3; k++) r.near[k] = clamp_coord(b[k]);
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      r.region = REG_EDGE_AB;
      for (int k = 0; k < 3; k++) r.near[k] = project_coord(a[k], ab[k], d1, 0, 0, d1 - d3);
    end else if (d6 >= 0 && d6 >= d5) begin
      r.region = REG_VERT_C;
      for (int k = 0; k < 3; k++) r.near[k] = clamp_coord(c[k]);
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      r.region = REG_EDGE_AC;
      for (int k = 0; k < 3; k++) r.near[k] = project_coord(a[k], ac[k], d2, 0, 0, d2 - d6);
    end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
      r.region = REG_EDGE_BC;
      for (int k = 0; k < 3; k++) r.near[k] = project_coord(b[k], bc[k], e1, 0, 0, e1 + e2);
    end else begin
      den = va + vb + vc;
      if (den <= 0) begin
        // A flat triangle that reaches the face test falls back to vertex A.
        r.region = REG_VERT_A;
        r.degen  = 1'b1;
        for (int k = 0; k < 3; k++) r.near[k] = clamp_coord(a[k]);
      end else begin
        r.region = REG_FACE;
        for (int k = 0; k < 3; k++)
          r.near[k] = project_coord(a[k], ab[k], vb, ac[k], vc, den);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic coord_t near_coord(int centre, int span);
    int v;
    v = centre + $signed($urandom_range(0, 2 * span)) - span;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return coord_t'(v);
  endfunction

  task automatic add_query(int px, int py, int pz, int ax, int ay, int az,
                           int bx, int by, int bz, int cx, int cy, int cz);
    query_t q;
    q.p[0] = coord_t'(px); q.p[1] = coord_t'(py); q.p[2] = coord_t'(pz);
    q.a[0] = coord_t'(ax); q.a[1] = coord_t'(ay); q.a[2] = coord_t'(az);
    q.b[0] = coord_t'(bx); q.b[1] = coord_t'(by); q.b[2] = coord_t'(bz);
    q.c[0] = coord_t'(cx); q.c[1] = coord_t'(cy); q.c[2] = coord_t'(cz);
    pending_queries.push_back(q);
  endtask

  // A random query of one of several shapes. Most are compact triangles with
  // the point close by, so that every region is reached often; the rest are
  // raw full-range words and flat or collapsed triangles.
  function automatic query_t random_query();
    query_t q;
    int kind, span, centre[3], lerp;
    kind = $urandom_range(0, 99);
    span = ($urandom_range(0, 3) == 0) ? 8000 : $urandom_range(4, 600);
    for (int k = 0; k < 3; k++) centre[k] = $signed($urandom_range(0, 40000)) - 20000;
    for (int k = 0; k < 3; k++) begin
      q.a[k] = near_coord(centre[k], span);
      q.b[k] = near_coord(centre[k], span);
      q.c[k] = near_coord(centre[k], span);
      q.p[k] = near_coord(centre[k], 2 * span);
    end
    if (kind >= 65 && kind < 87) begin
      q = query_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else if (kind >= 87 && kind < 95) begin
      // C on the line through A and B.
      lerp = $signed($urandom_range(0, 6)) - 3;
      for (int k = 0; k < 3; k++)
        q.c[k] = near_coord($signed(q.a[k]) + lerp * ($signed(q.b[k]) - $signed(q.a[k])), 0);
    end else if (kind >= 95) begin
      // Two or three vertices in one place.
      q.b = q.a;
      if (kind >= 98) q.c = q.a;
      else if (kind == 97) begin
        q.b = q.c;
      end
    end
    return q;
  endfunction

  // Mostly short gaps, now and then a long one, and bursts with none at all.
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the next pending item, holding it while stalled.
  // --------------------------------------------------------------------------
  int  send_gap;
  bit  send_burst;

  always @(posedge clk_i or negedge rst_ni) begin
    query_t q;
    if (!rst_ni) begin
      valid_i    <= 1'b0;
      send_gap   <= 0;
      send_burst <= 1'b0;
      {point_x_i, point_y_i, point_z_i}    <= '0;
      {vert_a_x_i, vert_a_y_i, vert_a_z_i} <= '0;
      {vert_b_x_i, vert_b_y_i, vert_b_z_i} <= '0;
      {vert_c_x_i, vert_c_y_i, vert_c_z_i} <= '0;
    end else if (!valid_i || !stall_o) begin
      if ($urandom_range(0, 199) == 0) send_burst <= ~send_burst;
      if (send_gap > 0 || pending_queries.size() == 0) begin
        valid_i <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        q = pending_queries.pop_front();
        valid_i    <= 1'b1;
        point_x_i  <= q.p[0]; point_y_i  <= q.p[1]; point_z_i  <= q.p[2];
        vert_a_x_i <= q.a[0]; vert_a_y_i <= q.a[1]; vert_a_z_i <= q.a[2];
        vert_b_x_i <= q.b[0]; vert_b_y_i <= q.b[1]; vert_b_z_i <= q.b[2];
        vert_c_x_i <= q.c[0]; vert_c_y_i <= q.c[1]; vert_c_z_i <= q.c[2];
        send_gap   <= pick_gap(send_burst);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stall: random stretches, with bursts that never stall.
  // --------------------------------------------------------------------------
  int  hold_left;
  bit  take_burst;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i    <= 1'b0;
      hold_left  <= 0;
      take_burst <= 1'b0;
    end else begin
      if ($urandom_range(0, 249) == 0) take_burst <= ~take_burst;
      if (hold_left > 0) begin
        stall_i   <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        stall_i   <= 1'b0;
        hold_left <= ($urandom_range(0, 1) == 0) ? 0 : pick_gap(take_burst);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: records the expected result of every accepted item and checks
  // every accepted result against the oldest one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    query_t q;
    res_t   want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (valid_i && !stall_o) begin
        q.p[0] = point_x_i;  q.p[1] = point_y_i;  q.p[2] = point_z_i;
        q.a[0] = vert_a_x_i; q.a[1] = vert_a_y_i; q.a[2] = vert_a_z_i;
        q.b[0] = vert_b_x_i; q.b[1] = vert_b_y_i; q.b[2] = vert_b_z_i;
        q.c[0] = vert_c_x_i; q.c[1] = vert_c_y_i; q.c[2] = vert_c_z_i;
        owed_results.push_back(nearest_point(q));
      end
      if (valid_o && !stall_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with nothing expected: near %0d %0d %0d region %0d",
                   $time, near_x_o, near_y_o, near_z_o, region_o);
          error_count <= error_count + 1;
        end else begin
          want = owed_results.pop_front();
          checked_count <= checked_count + 1;
          region_hits[want.region] <= region_hits[want.region] + 1;
          if (want.degen) degen_hits <= degen_hits + 1;
          if (near_x_o !== want.near[0] || near_y_o !== want.near[1] ||
              near_z_o !== want.near[2] || region_o !== want.region ||
              degenerate_o !== want.degen) begin
            $display("%0t: mismatch: expected near %0d %0d %0d region %0d degen %0d",
                     $time, want.near[0], want.near[1], want.near[2], want.region,
                     want.degen);
            $display("%0t:           actual   near %0d %0d %0d region %0d degen %0d",
                     $time, near_x_o, near_y_o, near_z_o, region_o, degenerate_o);
            error_count <= error_count + 1;
          end
        end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, owed_results.size());
        $display("closest_point_on_triangle_tb: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed items, random items, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin
    error_count   = 0;
    cycle_count   = 0;
    checked_count = 0;
    degen_hits    = 0;
    foreach (region_hits[i]) region_hits[i] = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Right triangle in the z = 0 plane: one point in each region.
    add_query(-100, -100, 0,   0, 0, 0,   256, 0, 0,   0, 256, 0);
    add_query(400, -10, 0,     0, 0, 0,   256, 0, 0,   0, 256, 0);
    add_query(128, -50, 7,     0, 0, 0,   256, 0, 0,   0, 256, 0);
    add_query(-10, 400, 5,     0, 0, 0,   256, 0, 0,   0, 256, 0);
    add_query(-50, 128, -3,    0, 0, 0,   256, 0, 0,   0, 256, 0);
    add_query(200, 200, 0,     0, 0, 0,   256, 0, 0,   0, 256, 0);
    add_query(50, 60, 300,     0, 0, 0,   256, 0, 0,   0, 256, 0);
    // A query whose point lies in the Voronoi region of vertex C.
    add_query(1, 1, 9,         0, 0, 0,   2, 0, 0,     0, 2, 2);
    // Collinear and collapsed triangles, and zero-length edges.
    add_query(100, 50, 0,      0, 0, 0,   256, 0, 0,   512, 0, 0);
    add_query(300, 40, 20,     0, 0, 0,   512, 0, 0,   256, 0, 0);
    add_query(10, 20, 30,      5, 5, 5,   5, 5, 5,     5, 5, 5);
    add_query(50, 200, 0,      0, 0, 0,   0, 0, 0,     0, 256, 0);
    add_query(300, 300, 3,     100, 0, 0, 0, 256, 0,   0, 256, 0);
    // Extremes of every field.
    add_query(-32768, -32768, -32768, 32767, 32767, 32767,
              -32768, 32767, -32768, 32767, -32768, 32767);
    add_query(32767, 32767, 32767, -32768, -32768, -32768,
              32767, -32768, -32768, -32768, 32767, -32768);
    add_query(0, 0, 0,  -32768, -32768, 0,  32767, -32768, 0,  -32768, 32767, 0);
    add_query(0, 0, 32767, -32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0);
    add_query(-1, -1, -1,   32767, 32767, 32767,  32767, 32767, 32767,
              32767, 32767, 32767);
    add_query(-21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846,
              21845, 21845, -21846);

    for (int i = 0; i < NUM_RANDOM; i++) pending_queries.push_back(random_query());

    // Wait for the last item to go in and its result to come out.
    while (pending_queries.size() != 0 || valid_i || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("checked %0d results: vertex A %0d, B %0d, C %0d, edge AB %0d, AC %0d,",
             checked_count, region_hits[REG_VERT_A], region_hits[REG_VERT_B],
             region_hits[REG_VERT_C], region_hits[REG_EDGE_AB], region_hits[REG_EDGE_AC]);
    $display("edge BC %0d, face %0d, flat triangles %0d; %0d mismatches",
             region_hits[REG_EDGE_BC], region_hits[REG_FACE], degen_hits, error_count);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("closest_point_on_triangle_tb: clean");
    end else begin
      $display("closest_point_on_triangle_tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/cpt_pkg.sv
design/cpt_front.sv
design/cpt_cross.sv
design/cpt_numer.sv
design/cpt_div.sv
design/closest_point_on_triangle.sv
bench/closest_point_on_triangle_tb.sv
